>>> rtl/core/obfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfv_pkg
// Shared constants, types and depth helpers for the orthonormal basis pipeline.
// ----------------------------------------------------------------------------
package obfv_pkg;

	// port width of every vector component
	localparam int FIELD_W = 32;

	// default configuration
	localparam int COMPONENT_BITS_DEF = 32;
	localparam int FRACTION_BITS_DEF  = 16;

	// fixed stage counts of the pipeline parts
	localparam int FRONT_STAGES  = 6;
	localparam int SQUARE_STAGES = 3;
	localparam int FINAL_STAGES  = 2;

	// cyclic neighbors of each axis for the cross products
	localparam int NEXT_AXIS [3] = '{1, 2, 0};
	localparam int PREV_AXIS [3] = '{2, 0, 1};

	// one finished result
	typedef struct packed {
		logic [2:0][FIELD_W-1:0] second;
		logic [2:0][FIELD_W-1:0] third;
		logic                    degenerate;
	} result_t;

	// divider steps + root steps + rounding stages of one unit
	function automatic int unit_stages(input int frac);
		return (2 * frac + 3) + (frac + 2) + FINAL_STAGES;
	endfunction

	// total register stages from input to final rounding
	function automatic int pipe_depth(input int frac);
		return FRONT_STAGES + SQUARE_STAGES + unit_stages(frac);
	endfunction

endpackage

>>> rtl/core/orthonormal_basis_from_two_vectors.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthonormal_basis_from_two_vectors
// Builds an orthonormal basis from a primary axis and a suggested second
// axis: third = axis x hint, second = third x axis, both scaled to unit
// length and rounded to nearest; parallel or zero input returns the hint.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------
//   in      | in_valid / in_stall | axis_x..z, hint_x..z
//   out     | out_valid/out_stall | second_x..z, third_x..z, degenerate
//
// One request per cycle while in_stall is low. The pipeline depth is set by the
// division (2F+3 stages) and square root (F+2 stages) chains of the
// normalizers. Reset clears all valid bits and the output buffer.
// The pipeline stops only when the two-entry output buffer is full.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_two_vectors #(
	parameter int COMPONENT_BITS = obfv_pkg::COMPONENT_BITS_DEF,
	parameter int FRACTION_BITS  = obfv_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] axis_x,
	input  logic [31:0] axis_y,
	input  logic [31:0] axis_z,
	input  logic [31:0] hint_x,
	input  logic [31:0] hint_y,
	input  logic [31:0] hint_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] second_x,
	output logic [31:0] second_y,
	output logic [31:0] second_z,
	output logic [31:0] third_x,
	output logic [31:0] third_y,
	output logic [31:0] third_z,
	output logic        degenerate
);

	localparam int N       = COMPONENT_BITS;
	localparam int FW      = obfv_pkg::FIELD_W;
	localparam int LAT     = obfv_pkg::pipe_depth(FRACTION_BITS);
	localparam int DEG_LAT = LAT - obfv_pkg::FRONT_STAGES;

	logic                adv;
	logic [2:0][N-1:0]   axis_v, hint_v;
	logic [2:0][3*N-1:0] d_mag, c_ext;
	logic [2:0]          d_neg, c_neg;
	logic [2:0][2*N-1:0] c_mag;
	logic                deg_front;
	logic [2:0][N-1:0]   second_c, third_c;
	logic                vld_s  [LAT];
	logic [2:0][N-1:0]   hint_s [LAT];
	logic                deg_s  [DEG_LAT];
	obfv_pkg::result_t   res_c, main_q, spare_q;
	logic [1:0]          cnt_q;
	logic                push, pop;

	assign axis_v = {axis_z[N-1:0], axis_y[N-1:0], axis_x[N-1:0]};
	assign hint_v = {hint_z[N-1:0], hint_y[N-1:0], hint_x[N-1:0]};

	// pipeline moves unless the output buffer is full
	assign adv      = (cnt_q != 2'd2);
	assign in_stall = ~adv;

	obfv_front #(
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_front (
		.clk        (clk),
		.adv        (adv),
		.axis       (axis_v),
		.hint       (hint_v),
		.d_mag      (d_mag),
		.d_neg      (d_neg),
		.c_mag      (c_mag),
		.c_neg      (c_neg),
		.degenerate (deg_front)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_ext[i] = {{N{1'b0}}, c_mag[i]};
		end
	end

	obfv_norm #(
		.COMPONENT_BITS (COMPONENT_BITS),
		.FRACTION_BITS  (FRACTION_BITS)
	) u_norm_second (
		.clk     (clk),
		.adv     (adv),
		.vec_mag (d_mag),
		.vec_neg (d_neg),
		.comp    (second_c)
	);

	obfv_norm #(
		.COMPONENT_BITS (COMPONENT_BITS),
		.FRACTION_BITS  (FRACTION_BITS)
	) u_norm_third (
		.clk     (clk),
		.adv     (adv),
		.vec_mag (c_ext),
		.vec_neg (c_neg),
		.comp    (third_c)
	);

	// valid bits travel alongside the data stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < LAT; t++) begin
				vld_s[t] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int t = 1; t < LAT; t++) begin
				vld_s[t] <= vld_s[t-1];
			end
		end
	end

	// hint and degenerate flag delayed to the result stage
	always_ff @(posedge clk) begin
		if (adv) begin
			hint_s[0] <= hint_v;
			for (int t = 1; t < LAT; t++) begin
				hint_s[t] <= hint_s[t-1];
			end
			deg_s[0] <= deg_front;
			for (int t = 1; t < DEG_LAT; t++) begin
				deg_s[t] <= deg_s[t-1];
			end
		end
	end

	// result assembly
	always_comb begin
		res_c.degenerate = deg_s[DEG_LAT-1];
		for (int i = 0; i < 3; i++) begin
			if (deg_s[DEG_LAT-1]) begin
				res_c.second[i] = FW'($signed(hint_s[LAT-1][i]));
				res_c.third[i]  = '0;
			end else begin
				res_c.second[i] = FW'($signed(second_c[i]));
				res_c.third[i]  = FW'($signed(third_c[i]));
			end
		end
	end

	// two-entry output buffer
	assign push = adv & vld_s[LAT-1];
	assign pop  = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == 2'd2) begin
			if (pop) begin
				main_q <= spare_q;
			end
		end else if (push) begin
			if (cnt_q == 2'd0 || pop) begin
				main_q <= res_c;
			end else begin
				spare_q <= res_c;
			end
		end
	end

	assign out_valid  = (cnt_q != 2'd0);
	assign second_x   = main_q.second[0];
	assign second_y   = main_q.second[1];
	assign second_z   = main_q.second[2];
	assign third_x    = main_q.third[0];
	assign third_y    = main_q.third[1];
	assign third_z    = main_q.third[2];
	assign degenerate = main_q.degenerate;

	// a full buffer always presents a result
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output buffer");

	// degenerate results carry a zero third axis
	a_degenerate_third: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> third_x == '0 && third_y == '0 && third_z == '0)
		else $error("degenerate result with nonzero third axis");

	// a frozen pipeline keeps its last stage
	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && vld_s[LAT-1] |=> vld_s[LAT-1])
		else $error("result lost while pipeline frozen");

endmodule

>>> rtl/core/obfv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfv_front
// Exact cross products: c = a x h, then d = c x a, in sign-magnitude form.
// ----------------------------------------------------------------------------
module obfv_front #(
	parameter int COMPONENT_BITS = obfv_pkg::COMPONENT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              adv,
	input  logic [2:0][COMPONENT_BITS-1:0]    axis,
	input  logic [2:0][COMPONENT_BITS-1:0]    hint,
	output logic [2:0][3*COMPONENT_BITS-1:0]  d_mag,
	output logic [2:0]                        d_neg,
	output logic [2:0][2*COMPONENT_BITS-1:0]  c_mag,
	output logic [2:0]                        c_neg,
	output logic                              degenerate
);

	localparam int N  = COMPONENT_BITS;
	localparam int CW = 2 * N + 1;
	localparam int MW = 3 * N;

	logic [2:0][2*N-1:0] p_s1, q_s1;
	logic [2:0][N-1:0]   a_s1, a_s2;
	logic [2:0][CW-1:0]  c_s2;
	logic [2:0][CW-1:0]  c_abs;
	logic [2:0][N-1:0]   a_abs;
	logic [2:0][2*N-1:0] c_mag_s3, c_mag_s4, c_mag_s5, c_mag_s6;
	logic [2:0]          c_neg_s3, c_neg_s4, c_neg_s5, c_neg_s6;
	logic [2:0][N-1:0]   a_mag_s3;
	logic [2:0]          a_neg_s3;
	logic                deg_s3, deg_s4, deg_s5, deg_s6;
	logic [2:0][2*N-1:0] pl_s4, ph_s4, ql_s4, qh_s4;
	logic [2:0]          pn_s4, qn_s4, pn_s5, qn_s5;
	logic [2:0][MW-1:0]  pm_s5, qm_s5;
	logic [2:0][MW-1:0]  sum_c, rdif_c;
	logic [2:0][MW:0]    dif_c;
	logic [2:0][MW-1:0]  d_mag_s6;
	logic [2:0]          d_neg_s6;

	// stage 1: signed component products of a x h
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= $signed(axis[obfv_pkg::NEXT_AXIS[i]])
					* $signed(hint[obfv_pkg::PREV_AXIS[i]]);
				q_s1[i] <= $signed(axis[obfv_pkg::PREV_AXIS[i]])
					* $signed(hint[obfv_pkg::NEXT_AXIS[i]]);
			end
			a_s1 <= axis;
		end
	end

	// stage 2: c = p - q, exact
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= {p_s1[i][2*N-1], p_s1[i]} - {q_s1[i][2*N-1], q_s1[i]};
			end
			a_s2 <= a_s1;
		end
	end

	// stage 3: magnitudes and signs, zero test
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_abs[i] = c_s2[i][CW-1] ? (~c_s2[i] + CW'(1)) : c_s2[i];
			a_abs[i] = a_s2[i][N-1] ? (~a_s2[i] + N'(1)) : a_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				c_mag_s3[i] <= c_abs[i][2*N-1:0];
				c_neg_s3[i] <= c_s2[i][CW-1];
				a_mag_s3[i] <= a_abs[i];
				a_neg_s3[i] <= a_s2[i][N-1];
			end
			deg_s3 <= (c_s2 == '0);
		end
	end

	// stage 4: partial products of d = c x a, c split in two halves
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pl_s4[i] <= c_mag_s3[obfv_pkg::NEXT_AXIS[i]][N-1:0]
					* a_mag_s3[obfv_pkg::PREV_AXIS[i]];
				ph_s4[i] <= c_mag_s3[obfv_pkg::NEXT_AXIS[i]][2*N-1:N]
					* a_mag_s3[obfv_pkg::PREV_AXIS[i]];
				ql_s4[i] <= c_mag_s3[obfv_pkg::PREV_AXIS[i]][N-1:0]
					* a_mag_s3[obfv_pkg::NEXT_AXIS[i]];
				qh_s4[i] <= c_mag_s3[obfv_pkg::PREV_AXIS[i]][2*N-1:N]
					* a_mag_s3[obfv_pkg::NEXT_AXIS[i]];
				pn_s4[i] <= c_neg_s3[obfv_pkg::NEXT_AXIS[i]]
					^ a_neg_s3[obfv_pkg::PREV_AXIS[i]];
				qn_s4[i] <= c_neg_s3[obfv_pkg::PREV_AXIS[i]]
					^ a_neg_s3[obfv_pkg::NEXT_AXIS[i]];
			end
			c_mag_s4 <= c_mag_s3;
			c_neg_s4 <= c_neg_s3;
			deg_s4   <= deg_s3;
		end
	end

	// stage 5: join halves into full product magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pm_s5[i] <= {ph_s4[i], {N{1'b0}}} + MW'(pl_s4[i]);
				qm_s5[i] <= {qh_s4[i], {N{1'b0}}} + MW'(ql_s4[i]);
			end
			pn_s5    <= pn_s4;
			qn_s5    <= qn_s4;
			c_mag_s5 <= c_mag_s4;
			c_neg_s5 <= c_neg_s4;
			deg_s5   <= deg_s4;
		end
	end

	// stage 6: sign-magnitude difference, both orders side by side
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i]  = pm_s5[i] + qm_s5[i];
			dif_c[i]  = {1'b0, pm_s5[i]} - {1'b0, qm_s5[i]};
			rdif_c[i] = qm_s5[i] - pm_s5[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (pn_s5[i] != qn_s5[i]) begin
					d_mag_s6[i] <= sum_c[i];
					d_neg_s6[i] <= pn_s5[i];
				end else if (dif_c[i][MW]) begin
					d_mag_s6[i] <= rdif_c[i];
					d_neg_s6[i] <= ~pn_s5[i];
				end else begin
					d_mag_s6[i] <= dif_c[i][MW-1:0];
					d_neg_s6[i] <= pn_s5[i];
				end
			end
			c_mag_s6 <= c_mag_s5;
			c_neg_s6 <= c_neg_s5;
			deg_s6   <= deg_s5;
		end
	end

	assign d_mag      = d_mag_s6;
	assign d_neg      = d_neg_s6;
	assign c_mag      = c_mag_s6;
	assign c_neg      = c_neg_s6;
	assign degenerate = deg_s6;

endmodule

>>> rtl/core/obfv_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfv_unit
// One unit component: round(|v| * 2^F / sqrt(S)) as isqrt(floor(v^2 4^(F+1) / S))
// halved with rounding, then saturated and signed. Fully pipelined.
// ----------------------------------------------------------------------------
module obfv_unit #(
	parameter int COMPONENT_BITS = obfv_pkg::COMPONENT_BITS_DEF,
	parameter int FRACTION_BITS  = obfv_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        adv,
	input  logic [6*COMPONENT_BITS-1:0] v2,
	input  logic [6*COMPONENT_BITS-1:0] den,
	input  logic                        neg,
	output logic [COMPONENT_BITS-1:0]   comp
);

	localparam int N      = COMPONENT_BITS;
	localparam int F      = FRACTION_BITS;
	localparam int SW     = 6 * N;
	localparam int QW     = 2 * F + 3;
	localparam int DSTEPS = 2 * F + 3;
	localparam int RTW    = F + 2;
	localparam int RSTEPS = F + 2;
	localparam int TW     = QW + 1;
	localparam int XW     = ((F + 1) > N ? (F + 1) : N) + 1;

	logic [SW-1:0]  rem_s  [DSTEPS];
	logic [SW-1:0]  den_s  [DSTEPS];
	logic [QW-1:0]  quo_s  [DSTEPS];
	logic           dneg_s [DSTEPS];
	logic [QW-1:0]  res_s  [RSTEPS];
	logic [RTW-1:0] root_s [RSTEPS];
	logic           rneg_s [RSTEPS];
	logic [F:0]     mag_s1;
	logic           neg_s1;
	logic [N-1:0]   comp_s2;
	logic [XW-1:0]  mag_x, lim_x, sat_x, neg_x;

	// restoring division, one quotient bit per stage
	for (genvar t = 0; t < DSTEPS; t++) begin : g_div
		logic [SW-1:0] rem_in, den_in;
		logic [QW-1:0] quo_in;
		logic          neg_in;
		logic [SW+1:0] diff;
		logic [SW:0]   twice;
		if (t == 0) begin : g_first
			assign twice  = {1'b0, v2};
			assign den_in = den;
			assign quo_in = '0;
			assign neg_in = neg;
			assign rem_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[t-1];
			assign twice  = {rem_in, 1'b0};
			assign den_in = den_s[t-1];
			assign quo_in = quo_s[t-1];
			assign neg_in = dneg_s[t-1];
		end
		assign diff = {1'b0, twice} - {2'b00, den_in};

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[t]  <= diff[SW+1] ? twice[SW-1:0] : diff[SW-1:0];
				quo_s[t]  <= {quo_in[QW-2:0], ~diff[SW+1]};
				den_s[t]  <= den_in;
				dneg_s[t] <= neg_in;
			end
		end
	end

	// integer square root of the quotient, one root bit per stage
	for (genvar t = 0; t < RSTEPS; t++) begin : g_root
		localparam int B = RSTEPS - 1 - t;
		logic [QW-1:0]  res_in;
		logic [RTW-1:0] root_in;
		logic           neg_in;
		logic [TW-1:0]  trial;
		logic           fits;
		if (t == 0) begin : g_first
			assign res_in  = quo_s[DSTEPS-1];
			assign root_in = '0;
			assign neg_in  = dneg_s[DSTEPS-1];
		end else begin : g_next
			assign res_in  = res_s[t-1];
			assign root_in = root_s[t-1];
			assign neg_in  = rneg_s[t-1];
		end
		// (y + 2^B)^2 - y^2 = y * 2^(B+1) + 4^B
		assign trial = TW'({root_in, {(B + 1){1'b0}}}) + (TW'(1) << (2 * B));
		assign fits  = trial <= TW'(res_in);

		always_ff @(posedge clk) begin
			if (adv) begin
				res_s[t]  <= fits ? QW'(TW'(res_in) - trial) : res_in;
				root_s[t] <= root_in | (RTW'(fits) << B);
				rneg_s[t] <= neg_in;
			end
		end
	end

	// halve with round up: (y + 1) >> 1
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= root_s[RSTEPS-1][RTW-1:1] + (F + 1)'(root_s[RSTEPS-1][0]);
			neg_s1 <= rneg_s[RSTEPS-1];
		end
	end

	// saturate to the component range and apply the sign
	always_comb begin
		mag_x = XW'(mag_s1);
		lim_x = XW'({(N - 1){1'b1}}) + XW'(neg_s1);
		sat_x = (mag_x > lim_x) ? lim_x : mag_x;
		neg_x = ~sat_x + XW'(1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			comp_s2 <= neg_s1 ? neg_x[N-1:0] : sat_x[N-1:0];
		end
	end

	assign comp = comp_s2;

endmodule

>>> rtl/core/obfv_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfv_norm
// Scales one vector to unit length: exact squares, squared norm, then one
// rounding unit per component.
// ----------------------------------------------------------------------------
module obfv_norm #(
	parameter int COMPONENT_BITS = obfv_pkg::COMPONENT_BITS_DEF,
	parameter int FRACTION_BITS  = obfv_pkg::FRACTION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             adv,
	input  logic [2:0][3*COMPONENT_BITS-1:0] vec_mag,
	input  logic [2:0]                       vec_neg,
	output logic [2:0][COMPONENT_BITS-1:0]   comp
);

	localparam int N  = COMPONENT_BITS;
	localparam int SW = 6 * N;

	logic [2:0][2*N-1:0] sq0_s1, sq1_s1, sq2_s1, x01_s1, x02_s1, x12_s1;
	logic [2:0]          neg_s1, neg_s2, neg_s3;
	logic [2:0][SW-1:0]  sq_s2, sq_s3;
	logic [SW-1:0]       sum_s3;

	// stage 1: chunk products, cross terms counted once
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq0_s1[i] <= vec_mag[i][N-1:0] * vec_mag[i][N-1:0];
				sq1_s1[i] <= vec_mag[i][2*N-1:N] * vec_mag[i][2*N-1:N];
				sq2_s1[i] <= vec_mag[i][3*N-1:2*N] * vec_mag[i][3*N-1:2*N];
				x01_s1[i] <= vec_mag[i][N-1:0] * vec_mag[i][2*N-1:N];
				x02_s1[i] <= vec_mag[i][N-1:0] * vec_mag[i][3*N-1:2*N];
				x12_s1[i] <= vec_mag[i][2*N-1:N] * vec_mag[i][3*N-1:2*N];
			end
			neg_s1 <= vec_neg;
		end
	end

	// stage 2: square; diagonal terms and the outer cross terms do not overlap
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= {sq2_s1[i], sq1_s1[i], sq0_s1[i]}
					+ SW'({x12_s1[i], x01_s1[i], {(N + 1){1'b0}}})
					+ SW'({x02_s1[i], {(2 * N + 1){1'b0}}});
			end
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: squared norm
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sq_s3  <= sq_s2;
			neg_s3 <= neg_s2;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_unit
		obfv_unit #(
			.COMPONENT_BITS (COMPONENT_BITS),
			.FRACTION_BITS  (FRACTION_BITS)
		) u_unit (
			.clk  (clk),
			.adv  (adv),
			.v2   (sq_s3[i]),
			.den  (sum_s3),
			.neg  (neg_s3[i]),
			.comp (comp[i])
		);
	end

endmodule
